@@ sv/lmbs_pkg.sv @@
// ---------------------------------------------------------------------------
// lmbs_pkg
// Shared types and constants of the LED matrix bit-plane scanner.
// ---------------------------------------------------------------------------
package lmbs_pkg;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned COLUMN_W    = 6;
  localparam int unsigned ROW_W       = 4;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned PIXEL_W     = 3 * COLOR_W;
  localparam int unsigned PLANE_W     = 3;
  localparam int unsigned ROW_ADDR_W  = 3;
  localparam int unsigned ON_TIME_W   = 9;
  localparam int unsigned PWIDTH_W    = 7;
  localparam int unsigned PHEIGHT_W   = 5;
  localparam int unsigned CFG_DATA_W  = 7;
  localparam int unsigned CFG_INDEX_W = 1;

  // Bit positions of the color channels inside a stored pixel.
  localparam int unsigned RED_LSB   = 2 * COLOR_W;
  localparam int unsigned GREEN_LSB = COLOR_W;
  localparam int unsigned BLUE_LSB  = 0;

  localparam logic [PWIDTH_W-1:0]  PANEL_WIDTH_RST  = 7'd32;
  localparam logic [PHEIGHT_W-1:0] PANEL_HEIGHT_RST = 5'd16;

  localparam logic [CFG_INDEX_W-1:0] CFG_PANEL_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PANEL_HEIGHT = 1'b1;

  typedef logic [PIXEL_W-1:0] pixel_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_SCAN  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_IDLE  = 1'b1
  } state_t;

  // Result fields that the controller registers; the color bits are picked
  // from the store read data afterwards.
  typedef struct packed {
    logic                  status;
    logic                  shift;
    logic                  latch;
    logic [ROW_ADDR_W-1:0] row_addr;
    logic [ON_TIME_W-1:0]  on_time_us;
    logic [PLANE_W-1:0]    plane;
  } result_t;

endpackage

@@ sv/led_matrix_bitplane_scanner.sv @@
// ---------------------------------------------------------------------------
// led_matrix_bitplane_scanner
// Binary code modulation scanner for a dual-scan RGB LED panel.
// ---------------------------------------------------------------------------
//   Channel   Ports                                  Handshake
//   request   start, busy, in_*                      start && !busy
//   result    out_valid, out_*                       one-cycle strobe
//   config    cfg_wr_en, cfg_index, cfg_data         write enable
//
// Pixel writes, scan steps and no-op requests are taken while idle; the result
// appears in the cycle after the request. A scan step reads the top and
// bottom pixels through the two read ports of the pixel memory.
// Clear sweeps all MAX_WIDTH*MAX_HEIGHT entries, one entry per cycle, with
// busy high. Reset starts the same sweep, so busy stays high after reset
// until the sweep ends. The receiver cannot stall results.
module led_matrix_bitplane_scanner #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [lmbs_pkg::MODE_W-1:0]       in_mode,
  input  logic [lmbs_pkg::COLUMN_W-1:0]     in_column,
  input  logic [lmbs_pkg::ROW_W-1:0]        in_row,
  input  logic [lmbs_pkg::COLOR_W-1:0]      in_red,
  input  logic [lmbs_pkg::COLOR_W-1:0]      in_green,
  input  logic [lmbs_pkg::COLOR_W-1:0]      in_blue,
  input  logic                              cfg_wr_en,
  input  logic [lmbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lmbs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  output logic                              out_status,
  output logic                              out_top_red,
  output logic                              out_top_green,
  output logic                              out_top_blue,
  output logic                              out_bottom_red,
  output logic                              out_bottom_green,
  output logic                              out_bottom_blue,
  output logic                              out_shift,
  output logic                              out_latch,
  output logic [lmbs_pkg::ROW_ADDR_W-1:0]   out_row_addr,
  output logic [lmbs_pkg::ON_TIME_W-1:0]    out_on_time_us,
  output logic [lmbs_pkg::PLANE_W-1:0]      out_plane
);
  import lmbs_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  pixel_t          mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr_top;
  logic [AW-1:0]   mem_raddr_bot;
  pixel_t          rd_top;
  pixel_t          rd_bot;
  logic            res_valid;
  result_t         res;

  lmbs_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_column     (in_column),
    .in_row        (in_row),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr_top (mem_raddr_top),
    .mem_raddr_bot (mem_raddr_bot),
    .res_valid     (res_valid),
    .res           (res)
  );

  lmbs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk         (clk),
    .wr_en       (mem_we),
    .wr_addr     (mem_waddr),
    .wr_data     (mem_wdata),
    .rd_en       (mem_re),
    .rd_addr_top (mem_raddr_top),
    .rd_addr_bot (mem_raddr_bot),
    .rd_top      (rd_top),
    .rd_bot      (rd_bot)
  );

  // Color bits come straight from the read data, selected by the plane of
  // the step; they are forced low for anything but a scan step.
  assign out_top_red      = res.shift & rd_top[RED_LSB   + res.plane];
  assign out_top_green    = res.shift & rd_top[GREEN_LSB + res.plane];
  assign out_top_blue     = res.shift & rd_top[BLUE_LSB  + res.plane];
  assign out_bottom_red   = res.shift & rd_bot[RED_LSB   + res.plane];
  assign out_bottom_green = res.shift & rd_bot[GREEN_LSB + res.plane];
  assign out_bottom_blue  = res.shift & rd_bot[BLUE_LSB  + res.plane];

  assign out_valid      = res_valid;
  assign out_status     = res.status;
  assign out_shift      = res.shift;
  assign out_latch      = res.latch;
  assign out_row_addr   = res.row_addr;
  assign out_on_time_us = res.on_time_us;
  assign out_plane      = res.plane;

endmodule

@@ sv/lmbs_store.sv @@
// ---------------------------------------------------------------------------
// lmbs_store
// Pixel memory: one write port and two registered read ports.
// ---------------------------------------------------------------------------
module lmbs_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  lmbs_pkg::pixel_t       wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr_top,
  input  logic [AW-1:0]          rd_addr_bot,
  output lmbs_pkg::pixel_t       rd_top,
  output lmbs_pkg::pixel_t       rd_bot
);
  import lmbs_pkg::*;

  pixel_t pixel_mem [DEPTH];
  pixel_t rd_top_r;
  pixel_t rd_bot_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pixel_mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next scan read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_top_r <= pixel_mem[rd_addr_top];
      rd_bot_r <= pixel_mem[rd_addr_bot];
    end
  end

  assign rd_top = rd_top_r;
  assign rd_bot = rd_bot_r;

endmodule

@@ sv/lmbs_ctrl.sv @@
// ---------------------------------------------------------------------------
// lmbs_ctrl
// Request decode, scan position, bit plane, panel size and clear sweep.
// ---------------------------------------------------------------------------
module lmbs_ctrl #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 16,
  parameter int unsigned AW         = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [lmbs_pkg::MODE_W-1:0]       in_mode,
  input  logic [lmbs_pkg::COLUMN_W-1:0]     in_column,
  input  logic [lmbs_pkg::ROW_W-1:0]        in_row,
  input  logic [lmbs_pkg::COLOR_W-1:0]      in_red,
  input  logic [lmbs_pkg::COLOR_W-1:0]      in_green,
  input  logic [lmbs_pkg::COLOR_W-1:0]      in_blue,
  input  logic                              cfg_wr_en,
  input  logic [lmbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lmbs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output lmbs_pkg::pixel_t                  mem_wdata,
  output logic                              mem_re,
  output logic [AW-1:0]                     mem_raddr_top,
  output logic [AW-1:0]                     mem_raddr_bot,
  output logic                              res_valid,
  output lmbs_pkg::result_t                 res
);
  import lmbs_pkg::*;

  localparam int unsigned DEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned EW        = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW        = (EW > PWIDTH_W) ? EW : PWIDTH_W;
  localparam int unsigned HEW       = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned HW        = (HEW > PHEIGHT_W) ? HEW : PHEIGHT_W;
  localparam int unsigned CLW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned PAIRS_MAX = MAX_HEIGHT / 2;
  localparam int unsigned RPW       = (PAIRS_MAX > 1) ? $clog2(PAIRS_MAX) : 1;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic [PWIDTH_W-1:0]    panel_width_r;
  logic [PHEIGHT_W-1:0]   panel_height_r;
  logic [CLW-1:0]         scan_col_r, scan_col_nxt;
  logic [RPW-1:0]         scan_row_r, scan_row_nxt;
  logic [PLANE_W-1:0]     plane_r, plane_nxt;
  logic                   res_valid_r;
  result_t                res_r, res_nxt;

  logic                   accept;
  mode_t                  mode;
  logic [WW-1:0]          pw, eff_w;
  logic [HW-1:0]          ph, h_sat, eff_h, pairs;
  logic                   wr_outside;
  logic [AW-1:0]          wr_addr;
  logic [CLW-1:0]         col_n;
  logic [RPW-1:0]         row_n;
  logic                   col_last, row_last;

  assign accept = start && !busy;
  assign mode   = mode_t'(in_mode);

  // Effective panel size, saturated into the range the store can hold; the height is rounded down to even.
  always_comb begin
    pw = WW'(panel_width_r);
    if (pw == '0) begin
      eff_w = WW'(1);
    end else if (pw > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = pw;
    end
    ph = HW'(panel_height_r);
    if (ph < HW'(2)) begin
      h_sat = HW'(2);
    end else if (ph > HW'(MAX_HEIGHT)) begin
      h_sat = HW'(MAX_HEIGHT);
    end else begin
      h_sat = ph;
    end
    eff_h = {h_sat[HW-1:1], 1'b0};
    pairs = eff_h >> 1;
  end

  assign wr_outside = (WW'(in_column) >= eff_w) || (HW'(in_row) >= eff_h);
  assign wr_addr    = AW'(AW'(in_row) * AW'(MAX_WIDTH)) + AW'(in_column);

  // A scan position left beyond a shrunken panel restarts at zero.
  assign col_n    = (WW'(scan_col_r) >= eff_w) ? '0 : scan_col_r;
  assign row_n    = (HW'(scan_row_r) >= pairs) ? '0 : scan_row_r;
  assign col_last = (WW'(col_n) + WW'(1)) >= eff_w;
  assign row_last = (HW'(row_n) + HW'(1)) >= pairs;

  assign mem_raddr_top = AW'(AW'(row_n) * AW'(MAX_WIDTH)) + AW'(col_n);
  assign mem_raddr_bot = AW'((AW'(row_n) + AW'(pairs)) * AW'(MAX_WIDTH)) + AW'(col_n);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r  <= PANEL_WIDTH_RST;
      panel_height_r <= PANEL_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PANEL_WIDTH:  panel_width_r  <= cfg_data[PWIDTH_W-1:0];
        CFG_PANEL_HEIGHT: panel_height_r <= cfg_data[PHEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt   = ST_IDLE;
          clr_cnt_nxt = '0;
        end
      end
      ST_IDLE: begin
        if (accept && (mode == MODE_CLEAR)) begin
          state_nxt   = ST_CLEAR;
          clr_cnt_nxt = '0;
        end
      end
      default: begin
        state_nxt   = ST_CLEAR;
        clr_cnt_nxt = '0;
      end
    endcase
  end

  // Memory controls and busy.
  always_comb begin
    busy      = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = {in_red, in_green, in_blue};
    mem_re    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        busy   = 1'b0;
        mem_we = accept && (mode == MODE_WRITE) && !wr_outside;
        mem_re = accept && (mode == MODE_SCAN);
      end
      default: ;
    endcase
  end

  // Result fields and scan position update.
  always_comb begin
    res_nxt      = '0;
    scan_col_nxt = scan_col_r;
    scan_row_nxt = scan_row_r;
    plane_nxt    = plane_r;
    if (accept) begin
      case (mode)
        MODE_WRITE: res_nxt.status = wr_outside;
        MODE_SCAN: begin
          res_nxt.shift = 1'b1;
          res_nxt.plane = plane_r;
          if (col_last) begin
            res_nxt.latch      = 1'b1;
            res_nxt.row_addr   = ROW_ADDR_W'(row_n);
            res_nxt.on_time_us = ON_TIME_W'(9'd2 << plane_r);
            scan_col_nxt       = '0;
            if (row_last) begin
              scan_row_nxt = '0;
              plane_nxt    = plane_r + PLANE_W'(1);
            end else begin
              scan_row_nxt = row_n + RPW'(1);
            end
          end else begin
            scan_col_nxt = col_n + CLW'(1);
            scan_row_nxt = row_n;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      scan_col_r  <= '0;
      scan_row_r  <= '0;
      plane_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      scan_col_r  <= scan_col_nxt;
      scan_row_r  <= scan_row_nxt;
      plane_r     <= plane_nxt;
      res_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// LED matrix bit-plane scanner testbench
// Sends pixel writes, scan steps, clears and no-op requests under several
// panel sizes, predicts every result from its own model of the pixel store
// and scan position, and checks every field of each result strobe.
// ---------------------------------------------------------------------------
module tb;
  import lmbs_pkg::*;

  localparam int unsigned PANEL_COLS = 64;
  localparam int unsigned PANEL_ROWS = 16;
  localparam int unsigned STORE_SIZE = PANEL_COLS * PANEL_ROWS;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    mode_t                mode;
    logic [COLUMN_W-1:0]  column;
    logic [ROW_W-1:0]     row;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
  } panel_req_t;

  typedef struct packed {
    logic                  status;
    logic                  top_red;
    logic                  top_green;
    logic                  top_blue;
    logic                  bottom_red;
    logic                  bottom_green;
    logic                  bottom_blue;
    logic                  shift;
    logic                  latch;
    logic [ROW_ADDR_W-1:0] row_addr;
    logic [ON_TIME_W-1:0]  on_time_us;
    logic [PLANE_W-1:0]    plane;
  } panel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [MODE_W-1:0] in_mode = '0;
  logic [COLUMN_W-1:0] in_column = '0;
  logic [ROW_W-1:0] in_row = '0;
  logic [COLOR_W-1:0] in_red = '0;
  logic [COLOR_W-1:0] in_green = '0;
  logic [COLOR_W-1:0] in_blue = '0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_status;
  logic out_top_red;
  logic out_top_green;
  logic out_top_blue;
  logic out_bottom_red;
  logic out_bottom_green;
  logic out_bottom_blue;
  logic out_shift;
  logic out_latch;
  logic [ROW_ADDR_W-1:0] out_row_addr;
  logic [ON_TIME_W-1:0] out_on_time_us;
  logic [PLANE_W-1:0] out_plane;

  led_matrix_bitplane_scanner #(
    .MAX_WIDTH(PANEL_COLS),
    .MAX_HEIGHT(PANEL_ROWS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_column(in_column),
    .in_row(in_row),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_top_red(out_top_red),
    .out_top_green(out_top_green),
    .out_top_blue(out_top_blue),
    .out_bottom_red(out_bottom_red),
    .out_bottom_green(out_bottom_green),
    .out_bottom_blue(out_bottom_blue),
    .out_shift(out_shift),
    .out_latch(out_latch),
    .out_row_addr(out_row_addr),
    .out_on_time_us(out_on_time_us),
    .out_plane(out_plane)
  );

  // Shadow copy of the block's state and registers.
  pixel_t pix_mem [STORE_SIZE];
  logic [PLANE_W-1:0] plane_q;
  int unsigned scan_row_q;
  int unsigned scan_col_q;
  logic [PWIDTH_W-1:0] width_reg;
  logic [PHEIGHT_W-1:0] height_reg;

  panel_req_t queued_cmds[$];
  panel_result_t awaited_outputs[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  logic req_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned gap_pct = 10;
  logic no_gaps = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned active_cols(int unsigned raw);
    if (raw < 1) return 1;
    if (raw > PANEL_COLS) return PANEL_COLS;
    return raw;
  endfunction

  function automatic int unsigned active_rows(int unsigned raw);
    int unsigned h;
    h = raw;
    if (h < 2) h = 2;
    if (h > PANEL_ROWS) h = PANEL_ROWS;
    return h & ~32'd1;
  endfunction

  // Applies one request to the shadow state and returns the result it causes.
  function automatic panel_result_t next_panel_output(panel_req_t rq);
    panel_result_t r;
    int unsigned w;
    int unsigned h;
    int unsigned pairs;
    int unsigned p;
    pixel_t top_px;
    pixel_t bot_px;
    r = '0;
    w = active_cols(32'(width_reg));
    h = active_rows(32'(height_reg));
    pairs = h / 2;
    case (rq.mode)
      MODE_WRITE: begin
        if (rq.column >= w || rq.row >= h) begin
          r.status = 1'b1;
        end else begin
          pix_mem[rq.row * PANEL_COLS + rq.column] = {rq.red, rq.green, rq.blue};
        end
      end
      MODE_SCAN: begin
        // A register change can leave the scan position outside the panel.
        if (scan_col_q >= w) scan_col_q = 0;
        if (scan_row_q >= pairs) scan_row_q = 0;
        p = 32'(plane_q);
        top_px = pix_mem[scan_row_q * PANEL_COLS + scan_col_q];
        bot_px = pix_mem[(scan_row_q + pairs) * PANEL_COLS + scan_col_q];
        r.top_red = top_px[RED_LSB + p];
        r.top_green = top_px[GREEN_LSB + p];
        r.top_blue = top_px[BLUE_LSB + p];
        r.bottom_red = bot_px[RED_LSB + p];
        r.bottom_green = bot_px[GREEN_LSB + p];
        r.bottom_blue = bot_px[BLUE_LSB + p];
        r.shift = 1'b1;
        r.plane = plane_q;
        if (scan_col_q + 1 >= w) begin
          r.latch = 1'b1;
          r.row_addr = scan_row_q[ROW_ADDR_W-1:0];
          r.on_time_us = 9'd2 << p;
          scan_col_q = 0;
          if (scan_row_q + 1 >= pairs) begin
            scan_row_q = 0;
            plane_q = plane_q + 1'b1;
          end else begin
            scan_row_q++;
          end
        end else begin
          scan_col_q++;
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < STORE_SIZE; i++) pix_mem[i] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic string result_str(panel_result_t r);
    return $sformatf("st=%0d top=%b%b%b bot=%b%b%b sh=%0d la=%0d ra=%0d on=%0d pl=%0d",
                     r.status, r.top_red, r.top_green, r.top_blue, r.bottom_red,
                     r.bottom_green, r.bottom_blue, r.shift, r.latch, r.row_addr,
                     r.on_time_us, r.plane);
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%s", msg);
  endtask

  // Result checking, register tracking and request capture share one edge so
  // that a result is always compared before the request accepted with it.
  always @(posedge clk) begin : check_proc
    panel_result_t got;
    panel_result_t want;
    panel_req_t rq;
    if (!rst_n) begin
      for (int i = 0; i < STORE_SIZE; i++) pix_mem[i] = '0;
      plane_q = '0;
      scan_row_q = 0;
      scan_col_q = 0;
      width_reg = PANEL_WIDTH_RST;
      height_reg = PANEL_HEIGHT_RST;
      req_taken <= 1'b0;
    end else begin
      if (out_valid === 1'b1) begin
        got.status = out_status;
        got.top_red = out_top_red;
        got.top_green = out_top_green;
        got.top_blue = out_top_blue;
        got.bottom_red = out_bottom_red;
        got.bottom_green = out_bottom_green;
        got.bottom_blue = out_bottom_blue;
        got.shift = out_shift;
        got.latch = out_latch;
        got.row_addr = out_row_addr;
        got.on_time_us = out_on_time_us;
        got.plane = out_plane;
        if (awaited_outputs.size() == 0) begin
          note_failure($sformatf("unexpected result at cycle %0d: %s", cycle_count,
                                 result_str(got)));
        end else begin
          want = awaited_outputs.pop_front();
          if (got !== want) begin
            note_failure($sformatf("mismatch at cycle %0d: expected %s, got %s",
                                   cycle_count, result_str(want), result_str(got)));
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PANEL_WIDTH: width_reg = cfg_data[PWIDTH_W-1:0];
          CFG_PANEL_HEIGHT: height_reg = cfg_data[PHEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        rq.mode = mode_t'(in_mode);
        rq.column = in_column;
        rq.row = in_row;
        rq.red = in_red;
        rq.green = in_green;
        rq.blue = in_blue;
        awaited_outputs.push_back(next_panel_output(rq));
      end
      req_taken <= start && !busy;
    end
  end

  // Request driver: holds a request until it is taken, with random gaps.
  always @(negedge clk) begin : drive_proc
    panel_req_t cur;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (queued_cmds.size() != 0 && !no_gaps && $urandom_range(99) < gap_pct) begin
        gap_left = $urandom_range(2);
        start <= 1'b0;
      end else if (queued_cmds.size() != 0) begin
        cur = queued_cmds.pop_front();
        start <= 1'b1;
        in_mode <= cur.mode;
        in_column <= cur.column;
        in_row <= cur.row;
        in_red <= cur.red;
        in_green <= cur.green;
        in_blue <= cur.blue;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("led_matrix_bitplane_scanner regression: fail");
      $finish;
    end
  end

  task automatic push_req(mode_t mode, int unsigned col, int unsigned row,
                          logic [7:0] r, logic [7:0] g, logic [7:0] b);
    panel_req_t rq;
    rq.mode = mode;
    rq.column = col[COLUMN_W-1:0];
    rq.row = row[ROW_W-1:0];
    rq.red = r;
    rq.green = g;
    rq.blue = b;
    queued_cmds.push_back(rq);
  endtask

  // Mostly scan steps and in-panel writes so the scan wraps through planes,
  // with some stray writes, no-ops and the odd clear.
  task automatic push_random(int unsigned w, int unsigned h);
    int unsigned roll;
    int unsigned col;
    int unsigned row;
    mode_t mode;
    roll = $urandom_range(99);
    col = $urandom_range(PANEL_COLS - 1);
    row = $urandom_range(PANEL_ROWS - 1);
    if (roll < 55) begin
      mode = MODE_SCAN;
    end else if (roll < 85) begin
      mode = MODE_WRITE;
      col = $urandom_range(w - 1);
      row = $urandom_range(h - 1);
    end else if (roll < 93) begin
      mode = MODE_WRITE;
    end else if (roll < 97) begin
      mode = MODE_NOP;
    end else begin
      mode = MODE_CLEAR;
    end
    push_req(mode, col, row, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (queued_cmds.size() != 0 || start || awaited_outputs.size() != 0 || busy);
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_panel(int unsigned raw_w, int unsigned raw_h);
    write_reg(CFG_PANEL_WIDTH, raw_w[CFG_DATA_W-1:0]);
    // Bits above the height register are don't-care and get random values.
    write_reg(CFG_PANEL_HEIGHT, {2'($urandom), raw_h[PHEIGHT_W-1:0]});
    @(posedge clk);
  endtask

  int unsigned phase_w [13] = '{1, 0, 127, 64, 1, 64, 3, 2, 5, 8, 0, 0, 4};
  int unsigned phase_h [13] = '{2, 0, 31, 16, 16, 2, 5, 4, 6, 3, 0, 0, 8};

  initial begin
    int unsigned raw_w;
    int unsigned raw_h;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry of 32 by 16: edges of the panel and one write past it.
    push_req(MODE_WRITE, 31, 15, 8'hff, 8'h00, 8'hff);
    push_req(MODE_WRITE, 32, 0, 8'h11, 8'h22, 8'h33);
    push_req(MODE_WRITE, 0, 8, 8'h80, 8'h01, 8'hc3);
    push_req(MODE_SCAN, 0, 0, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 40; i++) push_random(32, 16);
    wait_drained();

    // Tiny panel: plane advance, row pair wrap, clear and no-op.
    set_panel(2, 4);
    push_req(MODE_WRITE, 0, 0, 8'hff, 8'hff, 8'hff);
    push_req(MODE_WRITE, 1, 0, 8'h00, 8'h00, 8'h00);
    push_req(MODE_WRITE, 0, 2, 8'haa, 8'h55, 8'h0f);
    push_req(MODE_WRITE, 1, 3, 8'hf0, 8'h0f, 8'h81);
    push_req(MODE_WRITE, 0, 1, 8'h12, 8'h34, 8'h56);
    push_req(MODE_WRITE, 2, 0, 8'hff, 8'hff, 8'hff);
    push_req(MODE_WRITE, 0, 4, 8'hff, 8'hff, 8'hff);
    push_req(MODE_WRITE, 63, 15, 8'hff, 8'h00, 8'hff);
    for (int i = 0; i < 8; i++) push_req(MODE_SCAN, 63, 15, 8'hff, 8'hff, 8'hff);
    push_req(MODE_NOP, 63, 15, 8'hff, 8'hff, 8'hff);
    push_req(MODE_CLEAR, 0, 0, 8'h00, 8'h00, 8'h00);
    push_req(MODE_SCAN, 0, 0, 8'h00, 8'h00, 8'h00);
    push_req(MODE_SCAN, 0, 0, 8'h00, 8'h00, 8'h00);
    wait_drained();

    for (int ph = 0; ph < 13; ph++) begin
      raw_w = phase_w[ph];
      raw_h = phase_h[ph];
      if (ph == 10 || ph == 11) begin
        raw_w = ($urandom_range(2) == 0) ? $urandom_range(127) : $urandom_range(1, 9);
        raw_h = $urandom_range(31);
      end
      gap_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 10 : 35);
      no_gaps = (ph == 12);
      set_panel(raw_w, raw_h);
      for (int i = 0; i < 62; i++) push_random(active_cols(raw_w), active_rows(raw_h));
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && awaited_outputs.size() == 0) begin
      $display("led_matrix_bitplane_scanner regression: pass");
    end else begin
      $display("led_matrix_bitplane_scanner regression: fail");
    end
    $finish;
  end

endmodule
